/* design/cordic_atan2_binary_angle_top_assert.svh */
// Assertion macros for the checker file of the angle block.
`ifndef CORDIC_ATAN2_BINARY_ANGLE_TOP_ASSERT_SVH
`define CORDIC_ATAN2_BINARY_ANGLE_TOP_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define CAB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CAB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/cab_pkg.sv */
package cab_pkg;

   localparam int ITERATIONS_DEFAULT  = 14;
   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int TABLE_LEN           = 14;
   localparam int INPUT_WIDTH         = 32;
   localparam int ANGLE_WIDTH         = 16;

   typedef logic [ANGLE_WIDTH-1:0] angle_type;

   localparam angle_type ANGLE_ZERO          = 16'd0;
   localparam angle_type ANGLE_QUARTER       = 16'd16384;
   localparam angle_type ANGLE_HALF          = 16'd32768;
   localparam angle_type ANGLE_THREE_QUARTER = 16'd49152;

   // Arctangent of 2^-i in binary angle units.
   localparam angle_type ATAN_TABLE [TABLE_LEN] = '{
      16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163,
      16'd81,   16'd41,   16'd20,   16'd10,   16'd5,   16'd3,   16'd1
   };

   // Control bits that travel with each request through the pipeline.
   typedef struct packed {
      logic valid;
      logic bypass;
   } stage_ctl_type;

endpackage

/* design/cab_prep.sv */
module cab_prep #(
   parameter int COORD_WIDTH = cab_pkg::COORD_WIDTH_DEFAULT,
   parameter int INT_WIDTH   = COORD_WIDTH + 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [cab_pkg::INPUT_WIDTH-1:0]     in_y_coord,
   input  logic [cab_pkg::INPUT_WIDTH-1:0]     in_x_coord,
   output logic                                in_ready,
   output cab_pkg::stage_ctl_type              out_ctl,
   output logic signed [INT_WIDTH-1:0]         out_x,
   output logic signed [INT_WIDTH-1:0]         out_y,
   output cab_pkg::angle_type                  out_angle,
   input  logic                                out_ready
);

   logic [COORD_WIDTH-1:0]        y_raw;
   logic [COORD_WIDTH-1:0]        x_raw;
   logic signed [INT_WIDTH-1:0]   y_ext;
   logic signed [INT_WIDTH-1:0]   x_ext;
   logic                          x_zero;
   logic                          y_zero;

   cab_pkg::stage_ctl_type        ctl_ff, ctl_in;
   logic signed [INT_WIDTH-1:0]   x_ff, x_in;
   logic signed [INT_WIDTH-1:0]   y_ff, y_in;
   cab_pkg::angle_type            angle_ff, angle_in;

   assign y_raw  = in_y_coord[COORD_WIDTH-1:0];
   assign x_raw  = in_x_coord[COORD_WIDTH-1:0];
   assign y_ext  = {{(INT_WIDTH-COORD_WIDTH){y_raw[COORD_WIDTH-1]}}, y_raw};
   assign x_ext  = {{(INT_WIDTH-COORD_WIDTH){x_raw[COORD_WIDTH-1]}}, x_raw};
   assign x_zero = (x_raw == '0);
   assign y_zero = (y_raw == '0);

   assign in_ready = !ctl_ff.valid || out_ready;

   always_comb begin
      ctl_in.valid  = in_valid;
      ctl_in.bypass = x_zero;
      x_in          = x_ext;
      y_in          = y_ext;
      angle_in      = cab_pkg::ANGLE_ZERO;
      if (x_zero) begin
         // On the y axis the angle is known at once; the stages pass it through.
         if (y_zero) begin
            angle_in = cab_pkg::ANGLE_ZERO;
         end else if (y_raw[COORD_WIDTH-1]) begin
            angle_in = cab_pkg::ANGLE_THREE_QUARTER;
         end else begin
            angle_in = cab_pkg::ANGLE_QUARTER;
         end
      end else if (x_raw[COORD_WIDTH-1]) begin
         // Rotate by a half turn into the right half plane.
         x_in     = -x_ext;
         y_in     = -y_ext;
         angle_in = cab_pkg::ANGLE_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (in_ready) begin
         ctl_ff.valid <= ctl_in.valid;
         if (in_valid) begin
            ctl_ff.bypass <= ctl_in.bypass;
            x_ff          <= x_in;
            y_ff          <= y_in;
            angle_ff      <= angle_in;
         end
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_angle = angle_ff;

endmodule

/* design/cab_stage.sv */
module cab_stage #(
   parameter int INT_WIDTH = cab_pkg::COORD_WIDTH_DEFAULT + 2,
   parameter int STAGE     = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cab_pkg::stage_ctl_type        in_ctl,
   input  logic signed [INT_WIDTH-1:0]   in_x,
   input  logic signed [INT_WIDTH-1:0]   in_y,
   input  cab_pkg::angle_type            in_angle,
   output logic                          in_ready,
   output cab_pkg::stage_ctl_type        out_ctl,
   output logic signed [INT_WIDTH-1:0]   out_x,
   output logic signed [INT_WIDTH-1:0]   out_y,
   output cab_pkg::angle_type            out_angle,
   input  logic                          out_ready
);

   logic signed [INT_WIDTH-1:0]   shift_x;
   logic signed [INT_WIDTH-1:0]   shift_y;

   cab_pkg::stage_ctl_type        ctl_ff;
   logic signed [INT_WIDTH-1:0]   x_ff, x_in;
   logic signed [INT_WIDTH-1:0]   y_ff, y_in;
   cab_pkg::angle_type            angle_ff, angle_in;

   assign shift_x  = in_x >>> STAGE;
   assign shift_y  = in_y >>> STAGE;
   assign in_ready = !ctl_ff.valid || out_ready;

   // Rotate toward the x axis: clockwise while y is not negative.
   always_comb begin
      if (!in_y[INT_WIDTH-1]) begin
         x_in     = in_x + shift_y;
         y_in     = in_y - shift_x;
         angle_in = in_angle + cab_pkg::ATAN_TABLE[STAGE];
      end else begin
         x_in     = in_x - shift_y;
         y_in     = in_y + shift_x;
         angle_in = in_angle - cab_pkg::ATAN_TABLE[STAGE];
      end
      if (in_ctl.bypass) begin
         angle_in = in_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (in_ready) begin
         ctl_ff.valid <= in_ctl.valid;
         if (in_ctl.valid) begin
            ctl_ff.bypass <= in_ctl.bypass;
            x_ff          <= x_in;
            y_ff          <= y_in;
            angle_ff      <= angle_in;
         end
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_angle = angle_ff;

endmodule

/* design/cordic_atan2_binary_angle_top.sv */
// An accepted request passes first a register for sign extension, axis cases and half-turn
// folding, then a register for each CORDIC step.
// Throughput: one request per cycle; a stalled result holds the run of full stages behind
// it, while empty stages ahead of that run still take new requests.
// Reset is synchronous and clears the valid bit of every stage; data registers are not reset.
module cordic_atan2_binary_angle_top #(
   parameter int ITERATIONS  = cab_pkg::ITERATIONS_DEFAULT,
   parameter int COORD_WIDTH = cab_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cab_pkg::INPUT_WIDTH-1:0]   req_y_coord,
   input  logic [cab_pkg::INPUT_WIDTH-1:0]   req_x_coord,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cab_pkg::angle_type                rsp_angle
);

   localparam int INT_WIDTH = COORD_WIDTH + 2;

   cab_pkg::stage_ctl_type        ctl_s   [ITERATIONS+1];
   logic signed [INT_WIDTH-1:0]   x_s     [ITERATIONS+1];
   logic signed [INT_WIDTH-1:0]   y_s     [ITERATIONS+1];
   cab_pkg::angle_type            angle_s [ITERATIONS+1];
   logic                          ready_s [ITERATIONS+1];
   logic                          prep_ready;

   cab_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .INT_WIDTH   (INT_WIDTH)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_y_coord  (req_y_coord),
      .in_x_coord  (req_x_coord),
      .in_ready    (prep_ready),
      .out_ctl     (ctl_s[0]),
      .out_x       (x_s[0]),
      .out_y       (y_s[0]),
      .out_angle   (angle_s[0]),
      .out_ready   (ready_s[0])
   );

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      cab_stage #(
         .INT_WIDTH (INT_WIDTH),
         .STAGE     (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ctl_s[i]),
         .in_x      (x_s[i]),
         .in_y      (y_s[i]),
         .in_angle  (angle_s[i]),
         .in_ready  (ready_s[i]),
         .out_ctl   (ctl_s[i+1]),
         .out_x     (x_s[i+1]),
         .out_y     (y_s[i+1]),
         .out_angle (angle_s[i+1]),
         .out_ready (ready_s[i+1])
      );
   end

   assign ready_s[ITERATIONS] = !rsp_stall;
   assign req_stall           = !prep_ready;
   assign rsp_valid           = ctl_s[ITERATIONS].valid;
   assign rsp_angle           = angle_s[ITERATIONS];

endmodule

/* design/cab_checker.sv */
`include "cordic_atan2_binary_angle_top_assert.svh"

module cab_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [cab_pkg::INPUT_WIDTH-1:0]   req_y_coord,
   input logic [cab_pkg::INPUT_WIDTH-1:0]   req_x_coord,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input cab_pkg::angle_type                rsp_angle
);

   logic                                rsp_held;
   logic                                req_held;
   logic [2*cab_pkg::INPUT_WIDTH-1:0]   req_payload;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign req_held    = req_valid && req_stall;
   assign req_payload = {req_y_coord, req_x_coord};

   `CAB_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result valid right after reset")

   `CAB_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp_angle), "stalled result changed")

   `CAB_ASSERT(a_req_hold, req_held |=> req_valid && $stable(req_payload), "stalled request changed")

   `CAB_ASSERT(a_flow_through, !rsp_stall |-> !req_stall, "request stalled while results drain")

   `CAB_ASSERT(a_empty_takes, !rsp_valid |-> !req_stall, "request stalled with empty output stage")

endmodule

bind cordic_atan2_binary_angle_top cab_checker u_cab_checker (.*);

/* test/cordic_atan2_binary_angle_top_tb.sv */
`timescale 1ns / 1ps

module cordic_atan2_binary_angle_top_tb;

   localparam int RESET_CYCLES     = 11;
   localparam int COORD_W          = cab_pkg::COORD_WIDTH_DEFAULT;
   localparam int PATH_W           = COORD_W + 2;
   localparam int IN_W             = cab_pkg::INPUT_WIDTH;
   localparam int RANDOM_COUNT     = 1350;
   localparam int HOLD_AT          = 300;
   localparam int HOLD_ITEMS       = 60;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PAUSE_AT         = 700;
   localparam int DRAIN_CYCLES     = 2 * (cab_pkg::ITERATIONS_DEFAULT + 1);
   localparam int CYCLE_LIMIT      = 500000;
   localparam int DIRECTED_COUNT   = 24;

   localparam logic [IN_W-1:0] COORD_ZERO    = 32'h0000_0000;
   localparam logic [IN_W-1:0] COORD_ONE     = 32'h0000_0001;
   localparam logic [IN_W-1:0] COORD_NEG_ONE = 32'hFFFF_FFFF;
   localparam logic [IN_W-1:0] COORD_MAX     = 32'h7FFF_FFFF;
   localparam logic [IN_W-1:0] COORD_MIN     = 32'h8000_0000;

   localparam cab_pkg::angle_type A_ZERO    = cab_pkg::ANGLE_ZERO;
   localparam cab_pkg::angle_type A_QUARTER = cab_pkg::ANGLE_QUARTER;
   localparam cab_pkg::angle_type A_THREE_Q = cab_pkg::ANGLE_THREE_QUARTER;

   typedef struct packed {
      logic [IN_W-1:0]      y;
      logic [IN_W-1:0]      x;
      logic                 known;
      cab_pkg::angle_type   angle;
   } directed_row_type;

   // Rows with known set carry an angle that follows directly from the axis cases.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{COORD_ZERO,    COORD_ZERO,    1'b1, A_ZERO},
      '{COORD_ONE,     COORD_ZERO,    1'b1, A_QUARTER},
      '{COORD_MAX,     COORD_ZERO,    1'b1, A_QUARTER},
      '{COORD_NEG_ONE, COORD_ZERO,    1'b1, A_THREE_Q},
      '{COORD_MIN,     COORD_ZERO,    1'b1, A_THREE_Q},
      '{COORD_ZERO,    COORD_ONE,     1'b0, A_ZERO},
      '{COORD_ZERO,    COORD_MAX,     1'b0, A_ZERO},
      '{COORD_ZERO,    COORD_NEG_ONE, 1'b0, A_ZERO},
      '{COORD_ZERO,    COORD_MIN,     1'b0, A_ZERO},
      '{COORD_MAX,     COORD_MAX,     1'b0, A_ZERO},
      '{COORD_MIN,     COORD_MIN,     1'b0, A_ZERO},
      '{COORD_MAX,     COORD_MIN,     1'b0, A_ZERO},
      '{COORD_MIN,     COORD_MAX,     1'b0, A_ZERO},
      '{COORD_ONE,     COORD_ONE,     1'b0, A_ZERO},
      '{COORD_NEG_ONE, COORD_NEG_ONE, 1'b0, A_ZERO},
      '{COORD_ONE,     COORD_NEG_ONE, 1'b0, A_ZERO},
      '{COORD_NEG_ONE, COORD_ONE,     1'b0, A_ZERO},
      '{COORD_MAX,     COORD_ONE,     1'b0, A_ZERO},
      '{COORD_MIN,     COORD_NEG_ONE, 1'b0, A_ZERO},
      '{COORD_ONE,     COORD_MIN,     1'b0, A_ZERO},
      '{32'hFFFF_FFFD, 32'd1000,      1'b0, A_ZERO},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, A_ZERO},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, A_ZERO},
      '{32'h0000_FFFF, 32'hFFFF_0000, 1'b0, A_ZERO}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [IN_W-1:0]        req_y_coord = '0;
   logic [IN_W-1:0]        req_x_coord = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   cab_pkg::angle_type     rsp_angle;

   cab_pkg::angle_type     req_expected_angle = '0;
   logic                   hold_off_request = 1'b0;
   cab_pkg::angle_type     expected_angles [$];
   int                     error_count = 0;
   int                     cycle_count = 0;

   cordic_atan2_binary_angle_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_y_coord (req_y_coord),
      .req_x_coord (req_x_coord),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_angle   (rsp_angle)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic cab_pkg::angle_type predict_angle(logic [IN_W-1:0] y_raw,
                                                        logic [IN_W-1:0] x_raw);
      logic signed [PATH_W-1:0] vy;
      logic signed [PATH_W-1:0] vx;
      logic signed [PATH_W-1:0] ty;
      logic signed [PATH_W-1:0] tx;
      cab_pkg::angle_type       acc;
      vy = PATH_W'($signed(y_raw[COORD_W-1:0]));
      vx = PATH_W'($signed(x_raw[COORD_W-1:0]));
      acc = cab_pkg::ANGLE_ZERO;
      if (vx == 0 && vy == 0) return cab_pkg::ANGLE_ZERO;
      if (vx == 0) return (vy > 0) ? cab_pkg::ANGLE_QUARTER : cab_pkg::ANGLE_THREE_QUARTER;
      if (vx < 0) begin
         acc = cab_pkg::ANGLE_HALF;
         vx = -vx;
         vy = -vy;
      end
      for (int i = 0; i < cab_pkg::ITERATIONS_DEFAULT && i < cab_pkg::TABLE_LEN; i++) begin
         tx = vx;
         ty = vy;
         if (ty >= 0) begin
            vx = tx + (ty >>> i);
            vy = ty - (tx >>> i);
            acc = acc + cab_pkg::ATAN_TABLE[i];
         end else begin
            vx = tx - (ty >>> i);
            vy = ty + (tx >>> i);
            acc = acc - cab_pkg::ATAN_TABLE[i];
         end
      end
      return acc;
   endfunction

   // Mostly back-to-back, sometimes a few cycles, rarely a long gap.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [IN_W-1:0] random_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 32'($urandom_range(0, 32)) - 32'd16;
      if (r == 2) begin
         case ($urandom_range(0, 3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return COORD_ONE;
            default: return COORD_NEG_ONE;
         endcase
      end
      return $urandom;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic send_request(logic [IN_W-1:0] y, logic [IN_W-1:0] x,
                               cab_pkg::angle_type angle);
      req_valid <= 1'b1;
      req_y_coord <= y;
      req_x_coord <= x;
      req_expected_angle <= angle;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic idle_for(int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_angles.size() != 0);
   endtask

   always @(posedge clock) begin : scoreboard
      cab_pkg::angle_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               report_mismatch($sformatf("angle %0d with no request outstanding", rsp_angle));
            end else begin
               want = expected_angles.pop_front();
               if (rsp_angle !== want)
                  report_mismatch($sformatf("angle %0d, expected %0d", rsp_angle, want));
            end
         end
         if (req_valid && !req_stall) expected_angles.push_back(req_expected_angle);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // The receiver alternates ready and stalled runs; once, on request, it holds off
   // long enough for the pipeline to fill and push back on the sender.
   initial begin : receiver
      int  ready_run;
      int  stall_run;
      bit  held;
      held = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         if (hold_off_request && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            ready_run = ($urandom_range(0, 99) < 5) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 6);
            stall_run = pick_gap();
            rsp_stall <= 1'b0;
            repeat (ready_run) @(posedge clock);
            if (stall_run > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_run) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      logic [IN_W-1:0] y;
      logic [IN_W-1:0] x;
      int              kind;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].y, directed_rows[i].x,
                      directed_rows[i].known ? directed_rows[i].angle
                                             : predict_angle(directed_rows[i].y,
                                                             directed_rows[i].x));
         idle_for(pick_gap());
      end
      wait_for_results();

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == HOLD_AT) hold_off_request <= 1'b1;
         if (n == PAUSE_AT) wait_for_results();
         kind = $urandom_range(0, 9);
         y = random_coord();
         x = random_coord();
         if (kind == 0) x = COORD_ZERO;
         else if (kind == 1) y = COORD_ZERO;
         send_request(y, x, predict_angle(y, x));
         // No gaps while the receiver holds off, and in the first part of every hundred.
         if ((n >= HOLD_AT && n < HOLD_AT + HOLD_ITEMS) || (n % 100) < 30) idle_for(0);
         else idle_for(pick_gap());
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/cab_pkg.sv
design/cab_prep.sv
design/cab_stage.sv
design/cordic_atan2_binary_angle_top.sv
design/cab_checker.sv
test/cordic_atan2_binary_angle_top_tb.sv
